[rtl/mchh_pkg.sv]
// Package for the monotone chain half hull core: request/result structs and sizing constants.
// No dependencies; used by monotone_chain_half_hull_core.
package mchh_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int VIDX_W          = 6;

    localparam logic SIDE_UPPER = 1'b0;
    localparam logic SIDE_LOWER = 1'b1;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic                      last_point;
    } point_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] hull_x;
        logic signed [FIELD_W-1:0] hull_y;
        logic [VIDX_W-1:0]         vertex_index;
        logic                      last_vertex;
        logic                      overflow;
    } hull_res_t;

endpackage

[rtl/monotone_chain_half_hull_core.sv]
// Monotone chain half hull core: point stack in a memory, one shared multiplier for the
// turn test, small sequencer. Depends on mchh_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  request  | start / busy       | point (point_x, point_y, last_point)
//  result   | strobe (1 cycle)   | hull (hull_x, hull_y, vertex_index, ...)
//  config   | cfg_we             | cfg_data (hull_side)
//
// A point is pushed, then each turn test reads, forms differences, makes two multiplier passes
// and takes the sign and the pop; with three or more points stacked a point takes pops+1 tests,
// only pops when pruning stops at two points. A last point then starts emission, one memory read
// per hull vertex; each result shows in the cycle after its memory read.
// Reset clears the count, overflow flag, side and sequencer; the stack memory is not cleared.
// The receiver cannot stall; busy is high whenever the sequencer is out of idle (turn tests, emission).
module monotone_chain_half_hull_core #(
    parameter int MAX_POINTS  = mchh_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = mchh_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mchh_pkg::point_req_t point,
    output logic                 strobe,
    output mchh_pkg::hull_res_t  hull,
    input  logic                 cfg_we,
    input  logic                 cfg_data
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int T_W    = PROD_W + 1;
    localparam int ENT_W  = 2 * COORD_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] emit_idx_reg, emit_idx_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic              side_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [mchh_pkg::VIDX_W-1:0] out_idx_reg, out_idx_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    // stack memory, entry = {y, x}
    logic [ENT_W-1:0]  mem [MAX_POINTS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [ENT_W-1:0]  rd_a_reg, rd_b_reg;

    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic                          load_c;
    logic signed [DIFF_W-1:0]      bx_reg, by_reg, dx_reg, dy_reg;
    logic signed [PROD_W-1:0]      p1_reg, p2_reg;
    logic signed [DIFF_W-1:0]      mul_a, mul_b;
    logic signed [PROD_W-1:0]      mul_out;
    logic signed [T_W-1:0]         turn;
    logic                          pop;

    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
    logic signed [COORD_WIDTH-1:0] ox, oy;

    assign ax = rd_a_reg[COORD_WIDTH-1:0];
    assign ay = rd_a_reg[ENT_W-1:COORD_WIDTH];
    assign bx = rd_b_reg[COORD_WIDTH-1:0];
    assign by = rd_b_reg[ENT_W-1:COORD_WIDTH];

    // shared multiplier: B.x-A.x times C.y-A.y, then C.x-A.x times B.y-A.y
    assign mul_a   = (state_reg == S_MUL1) ? bx_reg : dx_reg;
    assign mul_b   = (state_reg == S_MUL1) ? dy_reg : by_reg;
    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign turn = T_W'(p1_reg) - T_W'(p2_reg);
    assign pop  = (side_reg == mchh_pkg::SIDE_LOWER) ? (turn <= 0) : (turn >= 0);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        emit_idx_next  = emit_idx_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        out_valid_next = 1'b0;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[ADDR_W-1:0];
        mem_wdata      = {point.point_y[COORD_WIDTH-1:0], point.point_x[COORD_WIDTH-1:0]};
        rd_en          = 1'b0;
        addr_a         = cnt_reg[ADDR_W-1:0] - ADDR_W'(3);
        addr_b         = cnt_reg[ADDR_W-1:0] - ADDR_W'(2);
        load_c         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = point.last_point;
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                    begin
                        mem_we   = 1'b1;
                        load_c   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg >= CNT_W'(2))
                            state_next = S_READ;
                        else if (point.last_point)
                            state_next = S_EMIT;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (point.last_point)
                            state_next = S_EMIT;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DEC;
            S_DEC:
            begin
                if (pop)
                begin
                    // middle point goes, newest point takes its slot
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg[ADDR_W-1:0] - ADDR_W'(2);
                    mem_wdata = {cy_reg, cx_reg};
                    cnt_next  = cnt_reg - 1'b1;
                end
                if (pop && cnt_reg > CNT_W'(3))
                    state_next = S_READ;
                else if (last_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                rd_en          = 1'b1;
                addr_b         = emit_idx_reg;
                out_valid_next = 1'b1;
                out_idx_next   = mchh_pkg::VIDX_W'(emit_idx_reg);
                out_last_next  = (CNT_W'(emit_idx_reg) + 1'b1 == cnt_reg);
                out_ovf_next   = ovf_reg;
                if (CNT_W'(emit_idx_reg) + 1'b1 == cnt_reg)
                begin
                    cnt_next      = '0;
                    ovf_next      = 1'b0;
                    emit_idx_next = '0;
                    state_next    = S_IDLE;
                end
                else
                    emit_idx_next = emit_idx_reg + 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            emit_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            side_reg      <= mchh_pkg::SIDE_UPPER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            emit_idx_reg  <= emit_idx_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                side_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
        if (load_c)
        begin
            cx_reg <= point.point_x[COORD_WIDTH-1:0];
            cy_reg <= point.point_y[COORD_WIDTH-1:0];
        end
        if (state_reg == S_DIFF)
        begin
            bx_reg <= DIFF_W'(bx) - DIFF_W'(ax);
            by_reg <= DIFF_W'(by) - DIFF_W'(ay);
            dx_reg <= DIFF_W'(cx_reg) - DIFF_W'(ax);
            dy_reg <= DIFF_W'(cy_reg) - DIFF_W'(ay);
        end
        if (state_reg == S_MUL1)
            p1_reg <= mul_out;
        if (state_reg == S_MUL2)
            p2_reg <= mul_out;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign ox = rd_b_reg[COORD_WIDTH-1:0];
    assign oy = rd_b_reg[ENT_W-1:COORD_WIDTH];

    assign busy                = (state_reg != S_IDLE);
    assign strobe              = out_valid_reg;
    assign hull.hull_x         = mchh_pkg::FIELD_W'(ox);
    assign hull.hull_y         = mchh_pkg::FIELD_W'(oy);
    assign hull.vertex_index   = out_idx_reg;
    assign hull.last_vertex    = out_last_reg;
    assign hull.overflow       = out_ovf_reg;

    // results only come out of the emission run
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == S_EMIT))
        else $error("result strobe without emission read");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("stack count past depth");

    a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && hull.last_vertex |-> cnt_reg == '0 && !ovf_reg && !busy)
        else $error("stack not cleared after final vertex");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cnt_reg == CNT_W'(MAX_POINTS) |=> ovf_reg)
        else $error("dropped point did not set overflow");

endmodule
